FILE: rtl/gh_pkg.sv
// Shared constants, types and helper functions of the thinning pass.
package gh_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RESET_SIZE = 1024;
    localparam int MIN_SIZE   = 3;

    localparam int SIZE_W    = 11;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WD_W      = $clog2(MAX_WIDTH + 1);
    localparam int HT_W      = $clog2(MAX_HEIGHT + 1);
    localparam int IN_ROW_W  = 2;
    localparam int ROW_READY = 2;
    localparam int WIN_COLS  = 3;
    localparam int CFG_IDX_W = 2;

    localparam int N_LOW  = 2;
    localparam int N_HIGH = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
        REG_IMAGE_HEIGHT = CFG_IDX_W'(1),
        REG_PASS_PARITY  = CFG_IDX_W'(2)
    } t_reg_idx;

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [WD_W-1:0]   t_width;
    typedef logic [HT_W-1:0]   t_height;
    typedef logic [2:0]        t_wcol;
    typedef logic [8:0]        t_window;

    typedef struct packed {
        logic interior;
        logic last_pixel;
    } t_pend;

    typedef struct packed {
        logic pixel_out;
        logic deleted;
        logic last_pixel;
    } t_result;

    function automatic t_width clamp_width(input logic [SIZE_W-1:0] v);
        t_width r;
        if (int'(v) < MIN_SIZE) begin
            r = WD_W'(MIN_SIZE);
        end else if (int'(v) > MAX_WIDTH) begin
            r = WD_W'(MAX_WIDTH);
        end else begin
            r = WD_W'(v);
        end
        return r;
    endfunction

    function automatic t_height clamp_height(input logic [SIZE_W-1:0] v);
        t_height r;
        if (int'(v) < MIN_SIZE) begin
            r = HT_W'(MIN_SIZE);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = HT_W'(MAX_HEIGHT);
        end else begin
            r = HT_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: rtl/gh_pix_if.sv
// Input pixel channel: valid, ready and one pixel or drain transaction.
interface gh_pix_if;
    logic valid;
    logic ready;
    logic pixel_in;
    logic drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

FILE: rtl/gh_res_if.sv
// Result channel: valid, ready and one thinned pixel transaction.
interface gh_res_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic deleted;
    logic last_pixel;

    modport source (output valid, output pixel_out, output deleted, output last_pixel,
                    input ready);
    modport sink (input valid, input pixel_out, input deleted, input last_pixel,
                  output ready);
endinterface

FILE: rtl/guo_hall_thinning_pass.sv
// Top level of one Guo-Hall thinning sub-iteration on a streamed binary raster.
//
//   Channel   Direction  Handshake         Payload
//   i_pix     in         valid / ready     pixel_in, drain
//   o_res     out        valid / ready     pixel_out, deleted, last_pixel
//   i_cfg_*   in         write enable      register index, 11-bit data
//
// One input transaction per clock is sustained while ready is high; each result passes the
// window cells and pending flags, then the output buffer, and the first width+1 transactions
// of a frame give none. A width change that puts the input column outside the new width drops
// ready for one cycle while the line store read port refetches. Synchronous active-low reset
// clears counters, window and handshake state, but not the line stores. Ready is low while the
// second output buffer entry is held.
module guo_hall_thinning_pass import gh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    gh_pix_if.sink               i_pix,
    gh_res_if.source             o_res
);

    t_width                r_w;
    t_height               r_h;
    logic                  r_parity;
    t_col                  r_ic, n_ic;
    logic [IN_ROW_W-1:0]   r_ir, n_ir;
    t_col                  r_oc, n_oc;
    t_height               r_or, n_or;
    t_col                  r_rd_col;
    logic                  r_pv;
    t_pend                 r_pend;
    logic                  r_ov, r_sv;
    t_result               r_out, r_skid;

    logic                  ic_wrap, oc_wrap;
    t_col                  u_ic, u_oc, raddr;
    logic [IN_ROW_W-1:0]   u_ir;
    t_height               u_or;
    t_width                ic1, oc1;
    logic                  px, in_ready, accept, res_due, take;
    t_pend                 pend_new;
    logic [1:0]            rdata;
    t_wcol                 w_col [WIN_COLS+1];
    t_window               win;
    t_result               w_res;

    function automatic logic [IN_ROW_W-1:0] inc_in_row(input logic [IN_ROW_W-1:0] v);
        return (v >= IN_ROW_W'(ROW_READY)) ? v : v + 1'b1;
    endfunction

    function automatic t_height inc_out_row(input t_height v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= clamp_width(SIZE_W'(RESET_SIZE));
            r_h      <= clamp_height(SIZE_W'(RESET_SIZE));
            r_parity <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_w      <= clamp_width(i_cfg_data);
                REG_IMAGE_HEIGHT: r_h      <= clamp_height(i_cfg_data);
                REG_PASS_PARITY:  r_parity <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        oc_wrap = (WD_W'(r_oc) >= r_w);
        u_oc    = oc_wrap ? '0 : r_oc;
        u_or    = oc_wrap ? inc_out_row(r_or) : r_or;
        ic_wrap = (WD_W'(r_ic) >= r_w);
        u_ic    = ic_wrap ? '0 : r_ic;
        u_ir    = ic_wrap ? inc_in_row(r_ir) : r_ir;

        px       = i_pix.drain ? 1'b0 : i_pix.pixel_in;
        in_ready = (r_rd_col == u_ic) && !r_sv;
        accept   = i_pix.valid && in_ready;
        res_due  = (u_ir >= IN_ROW_W'(ROW_READY)) || ((u_ir == IN_ROW_W'(1)) && (u_ic != '0));

        ic1 = WD_W'(u_ic) + WD_W'(1);
        oc1 = WD_W'(u_oc) + WD_W'(1);

        pend_new.last_pixel = (WD_W'(u_oc) >= r_w - WD_W'(1)) && (u_or >= r_h - HT_W'(1));
        pend_new.interior   = (u_or != '0) && (u_or < r_h - HT_W'(1)) && (u_oc != '0)
                              && (WD_W'(u_oc) < r_w - WD_W'(1));

        n_ic = r_ic;
        n_ir = r_ir;
        n_oc = r_oc;
        n_or = r_or;
        if (accept) begin
            if (ic1 >= r_w) begin
                n_ic = '0;
                n_ir = inc_in_row(u_ir);
            end else begin
                n_ic = ic1[COL_W-1:0];
                n_ir = u_ir;
            end
            n_oc = u_oc;
            n_or = u_or;
            if (res_due) begin
                if (pend_new.last_pixel) begin
                    n_ic = '0;
                    n_ir = '0;
                    n_oc = '0;
                    n_or = '0;
                end else if (oc1 >= r_w) begin
                    n_oc = '0;
                    n_or = inc_out_row(u_or);
                end else begin
                    n_oc = oc1[COL_W-1:0];
                end
            end
        end
        raddr = (WD_W'(n_ic) >= r_w) ? '0 : n_ic;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic     <= '0;
            r_ir     <= '0;
            r_oc     <= '0;
            r_or     <= '0;
            r_rd_col <= '0;
        end else begin
            r_ic     <= n_ic;
            r_ir     <= n_ir;
            r_oc     <= n_oc;
            r_or     <= n_or;
            r_rd_col <= raddr;
        end
    end

    gh_line_store u_lines (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (u_ic),
        .i_wdata ({rdata[0], px}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign w_col[WIN_COLS] = {px, rdata[0], rdata[1]};

    for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
        gh_win_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_col   (w_col[k+1]),
            .o_col   (w_col[k])
        );
    end

    assign win = {w_col[2][2], w_col[1][2], w_col[0][2],
                  w_col[2][1], w_col[1][1], w_col[0][1],
                  w_col[2][0], w_col[1][0], w_col[0][0]};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= pend_new;
        end
    end

    gh_thin_eval u_eval (
        .i_win    (win),
        .i_pend   (r_pend),
        .i_parity (r_parity),
        .o_res    (w_res)
    );

    assign take = r_ov && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_out  <= r_skid;
                r_skid <= w_res;
                r_sv   <= r_pv;
                r_pv   <= 1'b0;
            end
        end else begin
            if (r_pv) begin
                if (!r_ov || take) begin
                    r_out <= w_res;
                    r_ov  <= 1'b1;
                end else begin
                    r_skid <= w_res;
                    r_sv   <= 1'b1;
                end
            end else if (take) begin
                r_ov <= 1'b0;
            end
            r_pv <= accept && res_due;
        end
    end

    assign i_pix.ready      = in_ready;
    assign o_res.valid      = r_ov;
    assign o_res.pixel_out  = r_out.pixel_out;
    assign o_res.deleted    = r_out.deleted;
    assign o_res.last_pixel = r_out.last_pixel;

endmodule

FILE: rtl/gh_line_store.sv
// Two-line store, one word per column, with a registered read port and write forwarding.
module gh_line_store import gh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_we,
    input  t_col       i_waddr,
    input  logic [1:0] i_wdata,
    input  t_col       i_raddr,
    output logic [1:0] o_rdata
);

    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gh_win_cell.sv
// One column of the 3x3 window, loaded from its right-hand neighbour on each shift.
module gh_win_cell import gh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_wcol i_col,
    output t_wcol o_col
);

    t_wcol r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

FILE: rtl/gh_thin_eval.sv
// Guo-Hall deletion test on a 3x3 window, giving the thinned centre pixel.
module gh_thin_eval import gh_pkg::*; (
    input  t_window i_win,
    input  t_pend   i_pend,
    input  logic    i_parity,
    output t_result o_res
);

    logic p2, p3, p4, p5, p6, p7, p8, p9, center;
    logic [2:0] c, n1, n2, n;
    logic m, del;

    always_comb begin
        p9     = i_win[0];
        p2     = i_win[1];
        p3     = i_win[2];
        p8     = i_win[3];
        center = i_win[4];
        p4     = i_win[5];
        p7     = i_win[6];
        p6     = i_win[7];
        p5     = i_win[8];

        c  = {2'b00, ~p2 & (p3 | p4)} + {2'b00, ~p4 & (p5 | p6)}
           + {2'b00, ~p6 & (p7 | p8)} + {2'b00, ~p8 & (p9 | p2)};
        n1 = {2'b00, p9 | p2} + {2'b00, p3 | p4} + {2'b00, p5 | p6} + {2'b00, p7 | p8};
        n2 = {2'b00, p2 | p3} + {2'b00, p4 | p5} + {2'b00, p6 | p7} + {2'b00, p8 | p9};
        n  = (n1 < n2) ? n1 : n2;
        m  = i_parity ? ((p2 | p3 | ~p5) & p4) : ((p6 | p7 | ~p9) & p8);

        del = center && i_pend.interior && (c == 3'd1) && (n >= 3'(N_LOW))
              && (n <= 3'(N_HIGH)) && !m;

        o_res.pixel_out  = center & ~del;
        o_res.deleted    = del;
        o_res.last_pixel = i_pend.last_pixel;
    end

endmodule

FILE: rtl/gh_checker.sv
// Port-level checks of the thinning pass, bound to the top level.
module gh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_pixel_out,
    input logic i_deleted,
    input logic i_last_pixel
);

    logic r_after_last;
    logic out_fire;

    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b0;
        end else if (out_fire) begin
            r_after_last <= i_last_pixel;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_out)
        && $stable(i_deleted) && $stable(i_last_pixel))
        else $error("stalled result changed");

    a_frame_start_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_after_last |-> !i_deleted)
        else $error("first pixel of a frame deleted");

    a_no_double_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && i_last_pixel |=> !(out_fire && i_last_pixel))
        else $error("two consecutive frame ends");

endmodule

bind guo_hall_thinning_pass gh_checker u_gh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_pixel_out  (o_res.pixel_out),
    .i_deleted    (o_res.deleted),
    .i_last_pixel (o_res.last_pixel)
);
